// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked property that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: rtl/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg
// Types, character codes and helpers for the NMEA 0183 sentence parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_pkg;

    localparam logic [7:0] MAX_LEN_RESET = 8'd82;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_PROP   = 8'h50;  // 'P'
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // reject causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_NO_COMMA = 3'd1;
    localparam logic [2:0] CAUSE_BAD_HEX  = 3'd2;
    localparam logic [2:0] CAUSE_MISMATCH = 3'd3;
    localparam logic [2:0] CAUSE_FRAME    = 3'd4;

    // config register indexes
    localparam int          CFG_IDX_W        = 2;
    localparam logic [1:0]  CFG_MAX_LENGTH   = 2'd0;
    localparam logic [1:0]  CFG_ALLOW_DBL_LF = 2'd1;

    // output tdata layout: 86 bits of fields, padded to 88
    localparam int TDATA_W     = 88;
    localparam int CAUSE_LSB   = 83;
    localparam int SUMPRES_LSB = 74;

    typedef enum logic [8:0] {
        PH_HUNT  = 9'b000000001,
        PH_TALK  = 9'b000000010,
        PH_MSG   = 9'b000000100,
        PH_COMMA = 9'b000001000,
        PH_PAY   = 9'b000010000,
        PH_SUMHI = 9'b000100000,
        PH_SUMLO = 9'b001000000,
        PH_TERM1 = 9'b010000000,
        PH_TERM2 = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_char;
        logic [7:0]  payload_count;
        logic        is_encapsulated;
        logic [31:0] talker_code;
        logic        is_proprietary;
        logic [23:0] message_code;
        logic        checksum_present;
        logic [7:0]  checksum_value;
        logic [2:0]  reject_cause;
    } t_result;

    // hex digit value in bits 3:0, bit 4 set when the char is not hex
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/nmea_sentence_parser_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_parser_core
// Byte-serial NMEA 0183 sentence parser: header capture, payload forwarding,
// checksum check and one accept/reject verdict per sentence.
// ----------------------------------------------------------------------------
//  channel | dir | signals                              | item
//  --------+-----+--------------------------------------+----------------------
//  s       | in  | i_s_tvalid o_s_tready i_s_tdata[7:0]  | rx_byte
//  m       | out | o_m_tvalid i_m_tready o_m_tdata[87:0] | result fields
//          |     | o_m_tuser[1:0]                        | result_kind
//  cfg     | in  | i_cfg_valid o_cfg_ready i_cfg_index   | register write
//          |     | i_cfg_data[7:0]                       |
//
//  One byte per cycle while the output is not stalled; an accepted byte goes
//  into the input register, then through parse logic into the output
//  register, where its result is valid.
//  A byte yields zero or one result; bytes with no result just move state.
//  Sync active-low reset clears the parser to hunting and config to defaults.
//  A stalled output only blocks the parse stage; the input register still
//  holds one more byte before o_s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_parser_core
    import nmea_pkg::*;
#(
    parameter logic [7:0] MAX_LEN_DEFAULT = MAX_LEN_RESET
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [7:0]           i_s_tdata,    // [7:0] rx_byte
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [7:0] payload_char, [15:8] payload_count, [16] is_encapsulated,
    // [48:17] talker_code, [49] is_proprietary, [73:50] message_code,
    // [74] checksum_present, [82:75] checksum_value, [85:83] reject_cause,
    // [87:86] zero
    output logic [TDATA_W-1:0]        o_m_tdata,
    output logic [1:0]                o_m_tuser,    // [1:0] result_kind
    // config writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data
);

    // config
    logic [7:0] r_max_len;
    logic       r_dbl_lf;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_fpos,    n_fpos;
    logic [31:0] r_talker,  n_talker;
    logic [23:0] r_msg,     n_msg;
    logic        r_encap,   n_encap;
    logic        r_prop,    n_prop;
    logic [7:0]  r_xor,     n_xor;
    logic [7:0]  r_sum,     n_sum;
    logic        r_sum_seen, n_sum_seen;
    logic [7:0]  r_plen,    n_plen;
    logic [7:0]  r_span,    n_span;

    // output register
    logic    r_out_valid;
    t_result r_out;

    logic       advance;   // parse stage may write the output register
    logic       step;      // a byte is processed this cycle
    logic       emit;
    logic [1:0] res_kind;
    logic [7:0] res_char;
    logic [2:0] res_cause;
    logic [7:0] res_sum;   // checksum shown in the result
    t_result    res;

    logic [8:0] span_inc;
    logic [4:0] hex;
    logic       prop_now;
    logic [2:0] fpos_inc;
    logic       is_start;

    assign advance     = !r_out_valid || i_m_tready;
    assign step        = r_in_valid && advance;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign span_inc = {1'b0, r_span} + 9'd1;
    assign hex      = hex_value(r_in_byte);
    assign fpos_inc = r_fpos + 3'd1;
    assign prop_now = r_prop || ((r_fpos == 3'd0) && (r_in_byte == CH_PROP));
    assign is_start = (r_in_byte == CH_DOLLAR) || (r_in_byte == CH_BANG);

    // per-byte parse: phase decode, header shift, xor and checksum compare
    always_comb begin
        n_phase    = r_phase;
        n_fpos     = r_fpos;
        n_talker   = r_talker;
        n_msg      = r_msg;
        n_encap    = r_encap;
        n_prop     = r_prop;
        n_xor      = r_xor;
        n_sum      = r_sum;
        n_sum_seen = r_sum_seen;
        n_plen     = r_plen;
        n_span     = r_span;
        emit       = 1'b0;
        res_kind   = KIND_PAYLOAD;
        res_char   = 8'd0;
        res_cause  = CAUSE_NONE;
        res_sum    = r_sum;

        if (step) begin
            if (is_start) begin
                // start byte closes any open sentence, then restarts
                if (r_phase != PH_HUNT) begin
                    emit      = 1'b1;
                    res_kind  = KIND_REJECT;
                    res_cause = CAUSE_FRAME;
                end
                n_phase    = PH_TALK;
                n_fpos     = 3'd0;
                n_talker   = 32'd0;
                n_msg      = 24'd0;
                n_encap    = (r_in_byte == CH_BANG);
                n_prop     = 1'b0;
                n_xor      = 8'd0;
                n_sum      = 8'd0;
                n_sum_seen = 1'b0;
                n_plen     = 8'd0;
                n_span     = 8'd1;
            end else if (r_phase != PH_HUNT) begin
                if (span_inc > {1'b0, r_max_len}) begin
                    emit      = 1'b1;
                    res_kind  = KIND_REJECT;
                    res_cause = CAUSE_FRAME;
                    n_phase   = PH_HUNT;
                end else begin
                    n_span = span_inc[7:0];
                    case (r_phase)
                        PH_TALK: begin
                            if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_FRAME;
                                n_phase   = PH_HUNT;
                            end else begin
                                n_prop   = prop_now;
                                n_talker = {r_talker[23:0], r_in_byte};
                                n_xor    = r_xor ^ r_in_byte;
                                n_fpos   = fpos_inc;
                                if (fpos_inc >= (prop_now ? 3'd4 : 3'd2)) begin
                                    n_fpos  = 3'd0;
                                    n_phase = PH_MSG;
                                end
                            end
                        end
                        PH_MSG: begin
                            if (r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_FRAME;
                                n_phase   = PH_HUNT;
                            end else begin
                                n_msg  = {r_msg[15:0], r_in_byte};
                                n_xor  = r_xor ^ r_in_byte;
                                n_fpos = fpos_inc;
                                if (fpos_inc >= 3'd3) begin
                                    n_fpos  = 3'd0;
                                    n_phase = PH_COMMA;
                                end
                            end
                        end
                        PH_COMMA: begin
                            if (r_in_byte != CH_COMMA) begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_NO_COMMA;
                                n_phase   = PH_HUNT;
                            end else begin
                                n_xor   = r_xor ^ r_in_byte;
                                n_phase = PH_PAY;
                            end
                        end
                        PH_PAY: begin
                            if (r_in_byte == CH_STAR) begin
                                n_sum_seen = 1'b1;
                                n_fpos     = 3'd0;
                                n_phase    = PH_SUMHI;
                            end else if (r_in_byte == CH_CR) begin
                                n_phase = PH_TERM2;
                            end else if (r_in_byte == CH_LF) begin
                                if (!r_dbl_lf) begin
                                    emit      = 1'b1;
                                    res_kind  = KIND_REJECT;
                                    res_cause = CAUSE_FRAME;
                                    n_phase   = PH_HUNT;
                                end else begin
                                    n_phase = PH_TERM2;
                                end
                            end else begin
                                // forward; count shown is the pre-increment one
                                n_xor    = r_xor ^ r_in_byte;
                                emit     = 1'b1;
                                res_kind = KIND_PAYLOAD;
                                res_char = r_in_byte;
                                n_plen   = r_plen + 8'd1;
                            end
                        end
                        PH_SUMHI: begin
                            if (hex[4]) begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_BAD_HEX;
                                n_phase   = PH_HUNT;
                            end else begin
                                n_sum   = {hex[3:0], 4'd0};
                                n_fpos  = 3'd1;
                                n_phase = PH_SUMLO;
                            end
                        end
                        PH_SUMLO: begin
                            if (hex[4]) begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_BAD_HEX;
                                n_phase   = PH_HUNT;
                            end else begin
                                n_sum   = {r_sum[7:4], hex[3:0]};
                                n_fpos  = 3'd2;
                                res_sum = n_sum;  // mismatch verdict shows full value
                                if (n_sum != r_xor) begin
                                    emit      = 1'b1;
                                    res_kind  = KIND_REJECT;
                                    res_cause = CAUSE_MISMATCH;
                                    n_phase   = PH_HUNT;
                                end else begin
                                    n_phase = PH_TERM1;
                                end
                            end
                        end
                        PH_TERM1: begin
                            if (r_in_byte == CH_CR
                                    || (r_in_byte == CH_LF && r_dbl_lf)) begin
                                n_phase = PH_TERM2;
                            end else begin
                                emit      = 1'b1;
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_FRAME;
                                n_phase   = PH_HUNT;
                            end
                        end
                        PH_TERM2: begin
                            emit    = 1'b1;
                            n_phase = PH_HUNT;
                            if (r_in_byte != CH_LF) begin
                                res_kind  = KIND_REJECT;
                                res_cause = CAUSE_FRAME;
                            end else begin
                                res_kind = KIND_ACCEPT;
                            end
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
        end
    end

    // result snapshot uses the state as it stood before this byte, but a mismatch shows the full checksum
    always_comb begin
        res.kind             = res_kind;
        res.payload_char     = res_char;
        res.payload_count    = r_plen;
        res.is_encapsulated  = r_encap;
        res.talker_code      = r_talker;
        res.is_proprietary   = r_prop;
        res.message_code     = r_msg;
        res.checksum_present = (res_kind == KIND_PAYLOAD) ? 1'b0 : r_sum_seen;
        res.checksum_value   = (res_kind == KIND_PAYLOAD) ? 8'd0 : res_sum;
        res.reject_cause     = res_cause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_DEFAULT;
            r_dbl_lf  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH:   r_max_len <= i_cfg_data;
                CFG_ALLOW_DBL_LF: r_dbl_lf  <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_fpos     <= 3'd0;
            r_talker   <= 32'd0;
            r_msg      <= 24'd0;
            r_encap    <= 1'b0;
            r_prop     <= 1'b0;
            r_xor      <= 8'd0;
            r_sum      <= 8'd0;
            r_sum_seen <= 1'b0;
            r_plen     <= 8'd0;
            r_span     <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_fpos     <= n_fpos;
            r_talker   <= n_talker;
            r_msg      <= n_msg;
            r_encap    <= n_encap;
            r_prop     <= n_prop;
            r_xor      <= n_xor;
            r_sum      <= n_sum;
            r_sum_seen <= n_sum_seen;
            r_plen     <= n_plen;
            r_span     <= n_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
        if (advance && emit) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {2'b00,
                         r_out.reject_cause,
                         r_out.checksum_value,
                         r_out.checksum_present,
                         r_out.message_code,
                         r_out.is_proprietary,
                         r_out.talker_code,
                         r_out.is_encapsulated,
                         r_out.payload_count,
                         r_out.payload_char};

endmodule

`default_nettype wire

// File: rtl/nmea_checker.sv
// ----------------------------------------------------------------------------
// nmea_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nmea_checker
    import nmea_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [TDATA_W-1:0] o_m_tdata,
    input wire logic [1:0]         o_m_tuser
);

    logic                             stalled;
    logic                             is_payload;
    logic                             is_reject;
    logic                             kind_ok;
    logic [TDATA_W+1:0]               out_bus;
    logic [2:0]                       cause;
    logic [CAUSE_LSB+2-SUMPRES_LSB:0] sum_cause;   // checksum and cause bits

    assign stalled    = o_m_tvalid && !i_m_tready;
    assign is_payload = o_m_tvalid && (o_m_tuser == KIND_PAYLOAD);
    assign is_reject  = (o_m_tuser == KIND_REJECT);
    assign kind_ok    = (o_m_tuser == KIND_PAYLOAD) || (o_m_tuser == KIND_ACCEPT) || is_reject;
    assign out_bus    = {o_m_tuser, o_m_tdata};
    assign cause      = o_m_tdata[CAUSE_LSB+2:CAUSE_LSB];
    assign sum_cause  = o_m_tdata[CAUSE_LSB+2:SUMPRES_LSB];

    // a stalled result holds
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, stalled |=> (o_m_tvalid && $stable(out_bus)))

    // only the three defined kinds appear
    `ASSERT_CLK(a_kind, i_clk, i_rst_n, o_m_tvalid |-> kind_ok)

    // payload items carry no checksum and no cause
    `ASSERT_CLK(a_pay_clean, i_clk, i_rst_n, is_payload |-> (sum_cause == '0))

    // a cause is given exactly on rejects
    `ASSERT_CLK(a_cause, i_clk, i_rst_n, o_m_tvalid |-> (is_reject == (cause != CAUSE_NONE)))

endmodule

bind nmea_sentence_parser_core nmea_checker u_nmea_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
